>>> rtl/qshp_pkg.sv
package qshp_pkg;
	localparam int MaxElementsDefault = 64;
	localparam int ValueWidth = 32;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_POP,
		ST_POP_WAIT,
		ST_RANGE,
		ST_T_RD,
		ST_T_WAIT,
		ST_T_CMP,
		ST_P_RD,
		ST_P_WAIT,
		ST_P_PIV,
		ST_I_RD,
		ST_I_WAIT,
		ST_I_CMP,
		ST_J_RD,
		ST_J_WAIT,
		ST_J_CMP,
		ST_SWAP,
		ST_ADV,
		ST_PUSH_HI,
		ST_PUSH_LO,
		ST_OUT_RD,
		ST_OUT_WAIT,
		ST_OUT_HOLD
	} qshp_state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_STORE,
		CMD_INIT,
		CMD_POP,
		CMD_LATCH_RANGE,
		CMD_RD_PAIR,
		CMD_SWAP_PAIR,
		CMD_RD_LO,
		CMD_LATCH_PIVOT,
		CMD_RD_I,
		CMD_RD_J,
		CMD_INC_I,
		CMD_DEC_J,
		CMD_SWAP_IJ,
		CMD_ADVANCE,
		CMD_OUT_RD
	} qshp_cmd_op_t;

	typedef struct packed {
		qshp_cmd_op_t op;
		logic         push_hi;
		logic         push_lo;
		logic         tri_step_inc;
		logic         tri_clear;
		logic         out_load;
		logic         out_next;
		logic         done;
	} qshp_cmd_t;

	typedef struct packed {
		logic have_two;
		logic stack_empty;
		logic range_skip;
		logic range_tri;
		logic tri_swap;
		logic [1:0] tri_step;
		logic i_lt;
		logic j_gt;
		logic i_ge_j;
		logic out_last;
	} qshp_stat_t;
endpackage

>>> rtl/qshp_if.sv
interface qshp_in_if;
	logic                  valid;
	logic                  ready;
	logic signed [31:0]    value;
	logic                  last;
	modport source (output valid, value, last, input ready);
	modport sink (input valid, value, last, output ready);
endinterface

interface qshp_out_if;
	logic                  valid;
	logic                  ready;
	logic signed [31:0]    sorted_value;
	logic                  run_end;
	logic                  overflow;
	modport source (output valid, sorted_value, run_end, overflow, input ready);
	modport sink (input valid, sorted_value, run_end, overflow, output ready);
endinterface

>>> rtl/qshp_ram.sv
module qshp_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/qshp_datapath.sv
module qshp_datapath
	import qshp_pkg::*;
#(
	parameter int MaxElements = MaxElementsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qshp_cmd_t             cmd,
	input  logic signed [31:0]    in_value,
	output qshp_stat_t            stat,
	output logic signed [31:0]    out_value,
	output logic                  out_overflow
);
	localparam int Aw = (MaxElements > 1) ? $clog2(MaxElements) : 1;
	localparam int Cw = $clog2(MaxElements + 1);
	localparam int Sw = 2 * Aw;

	logic [Cw-1:0] count_q;
	logic          dropped_q;
	logic [Cw-1:0] sp_q;
	logic [Aw-1:0] lo_q, hi_q, i_q, j_q, k_q;
	logic [1:0]    tri_q;
	logic signed [31:0] pivot_q;

	// two memory ports are emulated with one RAM per copy kept coherent
	logic          we;
	logic [Aw-1:0] waddr, raddr_a, raddr_b;
	logic [31:0]   wdata, rdata_a, rdata_b;
	logic          swap_second_q;
	logic [Aw-1:0] sw_addr_q;
	logic [31:0]   sw_data_q;

	logic          s_we;
	logic [Aw-1:0] s_addr_w, s_addr_r;
	logic [Sw-1:0] s_wdata, s_rdata;

	logic [Aw-1:0] t0, t1;

	assign t0 = lo_q + Aw'(tri_q[0]);
	assign t1 = t0 + Aw'(1);

	qshp_ram #(.Width(32), .Depth(MaxElements)) u_ram_a (
		.clk, .we, .waddr, .wdata, .raddr(raddr_a), .rdata(rdata_a));
	qshp_ram #(.Width(32), .Depth(MaxElements)) u_ram_b (
		.clk, .we, .waddr, .wdata, .raddr(raddr_b), .rdata(rdata_b));
	qshp_ram #(.Width(Sw), .Depth(MaxElements)) u_stack (
		.clk, .we(s_we), .waddr(s_addr_w), .wdata(s_wdata), .raddr(s_addr_r),
		.rdata(s_rdata));

	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = in_value;
		raddr_a = i_q;
		raddr_b = j_q;
		if (swap_second_q) begin
			we = 1'b1;
			waddr = sw_addr_q;
			wdata = sw_data_q;
		end
		case (cmd.op)
			CMD_STORE: begin
				we = (count_q < Cw'(MaxElements));
				waddr = count_q[Aw-1:0];
				wdata = in_value;
			end
			CMD_RD_PAIR: begin
				raddr_a = t0;
				raddr_b = t1;
			end
			CMD_SWAP_PAIR: begin
				we = 1'b1;
				waddr = t0;
				wdata = rdata_b;
			end
			CMD_SWAP_IJ: begin
				we = 1'b1;
				waddr = i_q;
				wdata = rdata_b;
			end
			CMD_RD_LO: raddr_a = lo_q;
			CMD_OUT_RD: raddr_a = k_q;
			default: ;
		endcase
		// the whole set goes onto the stack as the first range
		s_we = cmd.push_hi | cmd.push_lo | (cmd.op == CMD_INIT);
		s_addr_w = (cmd.op == CMD_INIT) ? '0 : sp_q[Aw-1:0];
		if (cmd.op == CMD_INIT) s_wdata = {Aw'(0), Aw'(count_q - Cw'(1))};
		else s_wdata = cmd.push_hi ? {j_q + Aw'(1), hi_q} : {lo_q, j_q};
		// top entry read once the pointer has dropped
		s_addr_r = sp_q[Aw-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			dropped_q <= 1'b0;
			sp_q <= '0;
			tri_q <= '0;
			swap_second_q <= 1'b0;
		end else begin
			swap_second_q <= 1'b0;
			if (cmd.op == CMD_STORE) begin
				if (count_q < Cw'(MaxElements)) count_q <= count_q + Cw'(1);
				else dropped_q <= 1'b1;
			end
			if (cmd.op == CMD_INIT) begin
				sp_q <= Cw'(1);
			end
			if (cmd.op == CMD_POP) sp_q <= sp_q - Cw'(1);
			if ((cmd.push_hi || cmd.push_lo) && sp_q < Cw'(MaxElements))
				sp_q <= sp_q + Cw'(1);
			if (cmd.tri_clear) tri_q <= '0;
			if (cmd.tri_step_inc) tri_q <= tri_q + 2'd1;
			if (cmd.op == CMD_SWAP_PAIR) begin
				swap_second_q <= 1'b1;
			end
			if (cmd.op == CMD_SWAP_IJ) begin
				swap_second_q <= 1'b1;
			end
			if (cmd.done) begin
				count_q <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_INIT: begin
				lo_q <= '0;
				hi_q <= Aw'(count_q - Cw'(1));
				k_q <= '0;
			end
			CMD_LATCH_RANGE: begin
				lo_q <= s_rdata[Sw-1:Aw];
				hi_q <= s_rdata[Aw-1:0];
				i_q <= s_rdata[Sw-1:Aw];
				j_q <= s_rdata[Aw-1:0];
			end
			CMD_SWAP_PAIR: begin
				sw_addr_q <= t1;
				sw_data_q <= rdata_a;
			end
			CMD_LATCH_PIVOT: pivot_q <= rdata_a;
			CMD_INC_I: i_q <= i_q + Aw'(1);
			CMD_DEC_J: j_q <= j_q - Aw'(1);
			CMD_SWAP_IJ: begin
				sw_addr_q <= j_q;
				sw_data_q <= rdata_a;
			end
			CMD_ADVANCE: begin
				if (i_q < hi_q) i_q <= i_q + Aw'(1);
				if (j_q > lo_q) j_q <= j_q - Aw'(1);
			end
			default: ;
		endcase
		if (cmd.out_load) out_value <= rdata_a;
		if (cmd.out_next) k_q <= k_q + Aw'(1);
		if (cmd.op == CMD_STORE || cmd.done) k_q <= '0;
	end

	assign out_overflow = dropped_q;

	always_comb begin
		stat.have_two = (count_q >= Cw'(2));
		stat.stack_empty = (sp_q == '0);
		stat.range_skip = (s_rdata[Aw-1:0] <= s_rdata[Sw-1:Aw]) ||
			(Cw'(s_rdata[Aw-1:0]) >= count_q);
		stat.range_tri = (s_rdata[Aw-1:0] - s_rdata[Sw-1:Aw]) == Aw'(2);
		stat.tri_swap = $signed(rdata_b) < $signed(rdata_a);
		stat.tri_step = tri_q;
		stat.i_lt = (i_q < hi_q) && ($signed(rdata_a) < pivot_q);
		stat.j_gt = (j_q > lo_q) && (pivot_q < $signed(rdata_b));
		stat.i_ge_j = (i_q >= j_q);
		stat.out_last = (Cw'(k_q) + Cw'(1)) == count_q;
	end
endmodule

>>> rtl/qshp_ctrl.sv
module qshp_ctrl
	import qshp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_last,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_run_end,
	input  qshp_stat_t  stat,
	output qshp_cmd_t   cmd
);
	qshp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: if (in_valid && in_last) state_d = ST_INIT;
			ST_INIT: state_d = stat.have_two ? ST_POP : ST_OUT_RD;
			ST_POP: state_d = stat.stack_empty ? ST_OUT_RD : ST_POP_WAIT;
			ST_POP_WAIT: state_d = ST_RANGE;
			ST_RANGE: begin
				if (stat.range_skip) state_d = ST_POP;
				else if (stat.range_tri) state_d = ST_T_RD;
				else state_d = ST_P_RD;
			end
			ST_T_RD: state_d = ST_T_WAIT;
			ST_T_WAIT: state_d = ST_T_CMP;
			ST_T_CMP: state_d = (stat.tri_step == 2'd2) ? ST_POP : ST_T_RD;
			ST_P_RD: state_d = ST_P_WAIT;
			ST_P_WAIT: state_d = ST_P_PIV;
			ST_P_PIV: state_d = ST_I_RD;
			ST_I_RD: state_d = ST_I_WAIT;
			ST_I_WAIT: state_d = ST_I_CMP;
			ST_I_CMP: state_d = stat.i_lt ? ST_I_RD : ST_J_RD;
			ST_J_RD: state_d = ST_J_WAIT;
			ST_J_WAIT: state_d = ST_J_CMP;
			ST_J_CMP: begin
				if (stat.j_gt) state_d = ST_J_RD;
				else if (stat.i_ge_j) state_d = ST_PUSH_HI;
				else state_d = ST_SWAP;
			end
			ST_SWAP: state_d = ST_ADV;
			ST_ADV: state_d = ST_I_RD;
			ST_PUSH_HI: state_d = ST_PUSH_LO;
			ST_PUSH_LO: state_d = ST_POP;
			ST_OUT_RD: state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: if (out_ready) state_d = out_run_end ? ST_LOAD : ST_OUT_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	logic last_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_q <= 1'b0;
		else if (state_q == ST_OUT_WAIT) last_q <= stat.out_last;
	end
	assign out_run_end = last_q;

	always_comb begin
		cmd = '0;
		cmd.op = CMD_NONE;
		in_ready = (state_q == ST_LOAD);
		out_valid = (state_q == ST_OUT_HOLD);
		case (state_q)
			ST_LOAD: if (in_valid) cmd.op = CMD_STORE;
			ST_INIT: cmd.op = CMD_INIT;
			ST_POP: if (!stat.stack_empty) cmd.op = CMD_POP;
			ST_RANGE: begin
				cmd.op = CMD_LATCH_RANGE;
				cmd.tri_clear = 1'b1;
			end
			ST_T_RD: cmd.op = CMD_RD_PAIR;
			ST_T_WAIT: cmd.op = CMD_RD_PAIR;
			ST_T_CMP: begin
				if (stat.tri_swap) cmd.op = CMD_SWAP_PAIR;
				cmd.tri_step_inc = (stat.tri_step != 2'd2);
				cmd.tri_clear = (stat.tri_step == 2'd2);
			end
			ST_P_RD, ST_P_WAIT: cmd.op = CMD_RD_LO;
			ST_P_PIV: cmd.op = CMD_LATCH_PIVOT;
			ST_I_CMP: if (stat.i_lt) cmd.op = CMD_INC_I;
			ST_J_CMP: begin
				if (stat.j_gt) cmd.op = CMD_DEC_J;
				else if (stat.i_ge_j) cmd.push_hi = 1'b1;
			end
			ST_SWAP: cmd.op = CMD_SWAP_IJ;
			ST_ADV: cmd.op = CMD_ADVANCE;
			ST_PUSH_LO: cmd.push_lo = 1'b1;
			ST_OUT_RD, ST_OUT_WAIT: cmd.op = CMD_OUT_RD;
			ST_OUT_HOLD: begin
				cmd.out_next = out_ready;
				cmd.done = out_ready && out_run_end;
			end
			default: ;
		endcase
		cmd.out_load = (state_q == ST_OUT_WAIT);
	end
endmodule

>>> rtl/quicksort_hoare_partition_core.sv
// channel   dir  fields                            accepted when
// in_ch     in   value[31:0] last                  valid && ready
// out_ch    out  sorted_value[31:0] run_end overflow valid && ready
//
// loading accepts one item per cycle; the last item starts the sort
// sorting runs through a controller stepping synchronous-read rams;
// each compare steps through read, wait and compare states, a swap through swap and advance
// each result passes through read, wait and hold states and is held while the sink stalls
// arst_n clears control; the element store and range stack need no clear
module quicksort_hoare_partition_core
	import qshp_pkg::*;
#(
	parameter int MaxElements = MaxElementsDefault
) (
	input logic      clk,
	input logic      arst_n,
	qshp_in_if.sink  in_ch,
	qshp_out_if.source out_ch
);
	qshp_cmd_t  cmd;
	qshp_stat_t stat;

	// controller: load, sort sequencing and run emission
	qshp_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_last(in_ch.last), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_run_end(out_ch.run_end),
		.stat, .cmd);

	// datapath: element store, range stack, partition indices
	qshp_datapath #(.MaxElements(MaxElements)) u_dp (
		.clk, .arst_n, .cmd, .in_value(in_ch.value), .stat,
		.out_value(out_ch.sorted_value), .out_overflow(out_ch.overflow));

	// nothing accepted on input while a run is going out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("input taken during output");

	// a result held under stall keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> $stable(out_ch.sorted_value))
		else $error("payload changed under stall");

	// after the final item leaves, input opens again
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.ready && out_ch.run_end |=> in_ch.ready)
		else $error("input not reopened");
endmodule

>>> verif/tb_if.sv
`timescale 1ns / 100ps
// the block's channel interfaces live in the rtl tree; this file only hosts
// a small bundle used by the testbench to carry one expected result
package tb_sort_pkg;
	typedef struct {
		logic signed [31:0] sorted_value;
		logic               run_end;
		logic               overflow;
	} sort_result_t;
endpackage

>>> verif/tb.sv
`timescale 1ns / 100ps
module tb;
	import tb_sort_pkg::*;

	localparam int Cap = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qshp_in_if  in_ch();
	qshp_out_if out_ch();

	quicksort_hoare_partition_core #(.MaxElements(Cap)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #4 clk = ~clk;

	// predictor state: the set being gathered and the drop flag
	logic signed [31:0] set_buf[$];
	logic               set_dropped;
	sort_result_t       sorted_queue[$];
	int                 fail_count = 0;

	// signed sort of the gathered set into expected results
	task automatic predict_item(input logic signed [31:0] v, input logic lst);
		logic signed [31:0] arr[$];
		logic signed [31:0] t;
		sort_result_t r;
		if (set_buf.size() < Cap) set_buf.push_back(v);
		else set_dropped = 1'b1;
		if (lst) begin
			arr = set_buf;
			// insertion sort: same ordering as any correct ascending sort
			for (int a = 1; a < arr.size(); a++) begin
				t = arr[a];
				for (int b = a - 1; b >= 0 && arr[b] > t; b--) begin
					arr[b + 1] = arr[b];
					arr[b] = t;
				end
			end
			foreach (arr[k]) begin
				r.sorted_value = arr[k];
				r.run_end = (k == arr.size() - 1);
				r.overflow = set_dropped;
				sorted_queue.push_back(r);
			end
			set_buf.delete();
			set_dropped = 1'b0;
		end
	endtask

	// directed table: value, last, typed expectation, expected value
	typedef struct {
		logic signed [31:0] value;
		logic               last;
		logic               typed;
		logic signed [31:0] exp_value;
	} stim_row_t;

	stim_row_t directed[$];
	stim_row_t pending[$];

	// sender: bursts with random gaps
	task automatic send_item(input stim_row_t s);
		int gap;
		sort_result_t r;
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= s.value;
		in_ch.last <= s.last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (s.typed) begin
			// single-element run with its result typed in
			r.sorted_value = s.exp_value;
			r.run_end = 1'b1;
			r.overflow = 1'b0;
			sorted_queue.push_back(r);
		end else begin
			predict_item(s.value, s.last);
		end
	endtask

	task automatic drain_wait();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sorted_queue.size() != 0) @(posedge clk);
	endtask

	// random set, mostly full-range values, with extremes and small values mixed in
	task automatic add_random_set(input int n);
		stim_row_t s;
		s.typed = 1'b0;
		s.exp_value = '0;
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: s.value = 32'sh8000_0000;
				1: s.value = 32'sh7fff_ffff;
				2: s.value = $urandom_range(0, 7) - 3;
				default: s.value = $urandom;
			endcase
			s.last = (k == n - 1);
			pending.push_back(s);
		end
	endtask

	// receiver: its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 9) < 7);
		end
	end

	// checker on accepted results
	always @(posedge clk) begin
		sort_result_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (sorted_queue.size() == 0) begin
				$display("%0t: unexpected result %0d", $time, out_ch.sorted_value);
				fail_count++;
			end else begin
				e = sorted_queue.pop_front();
				if (out_ch.sorted_value !== e.sorted_value || out_ch.run_end !== e.run_end
						|| out_ch.overflow !== e.overflow) begin
					$display("%0t: expected %0d/%b/%b actual %0d/%b/%b", $time,
						e.sorted_value, e.run_end, e.overflow,
						out_ch.sorted_value, out_ch.run_end, out_ch.overflow);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int n;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		in_ch.last = 1'b0;
		set_buf.delete();
		set_dropped = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single element, pair of extremes, three-element range, duplicates, mixed signs with extremes
		directed = '{
			'{32'sd5, 1'b1, 1'b1, 32'sd5},
			'{32'sh7fff_ffff, 1'b0, 1'b0, 32'sd0}, '{32'sh8000_0000, 1'b1, 1'b0, 32'sd0},
			'{32'sd3, 1'b0, 1'b0, 32'sd0}, '{-32'sd1, 1'b0, 1'b0, 32'sd0},
			'{32'sd2, 1'b1, 1'b0, 32'sd0},
			'{32'sd7, 1'b0, 1'b0, 32'sd0}, '{32'sd7, 1'b0, 1'b0, 32'sd0},
			'{32'sd7, 1'b0, 1'b0, 32'sd0}, '{32'sd7, 1'b1, 1'b0, 32'sd0},
			'{32'sd0, 1'b0, 1'b0, 32'sd0}, '{-32'sd1, 1'b0, 1'b0, 32'sd0},
			'{32'sd1, 1'b0, 1'b0, 32'sd0}, '{32'sh8000_0000, 1'b0, 1'b0, 32'sd0},
			'{32'sh7fff_ffff, 1'b0, 1'b0, 32'sd0}, '{32'sd0, 1'b1, 1'b0, 32'sd0}
		};
		foreach (directed[k]) send_item(directed[k]);
		// only the first run is typed in: single element passes through
		drain_wait();

		// store full: one beyond capacity, then five beyond, then exactly at capacity, each with last
		add_random_set(Cap + 1);
		add_random_set(Cap + 5);
		add_random_set(Cap);
		while (pending.size() != 0) send_item(pending.pop_front());
		// hold off until everything has come back
		drain_wait();

		n = 0;
		while (n < 190) begin
			add_random_set(($urandom_range(0, 9) == 0) ? $urandom_range(30, 66)
				: $urandom_range(1, 12));
			n += pending.size();
			while (pending.size() != 0) send_item(pending.pop_front());
		end
		drain_wait();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && sorted_queue.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("tb NOT OK");
		$finish;
	end
endmodule

>>> files.f
rtl/qshp_pkg.sv
rtl/qshp_if.sv
rtl/qshp_ram.sv
rtl/qshp_datapath.sv
rtl/qshp_ctrl.sv
rtl/quicksort_hoare_partition_core.sv
verif/tb_if.sv
verif/tb.sv
